>>> rtl/jep_pkg.sv
// Shared types and constants for the Josephus elimination order block.
package jep_pkg;

    localparam int LABEL_W = 7;
    localparam int STEP_W  = 16;
    localparam int CNT_W   = $clog2(STEP_W);

    typedef struct packed {
        logic [LABEL_W-1:0] person_count;
        logic [LABEL_W-1:0] start_label;
        logic [STEP_W-1:0]  step_count;
    } t_req;

    typedef struct packed {
        logic [LABEL_W-1:0] removed_label;
        logic               is_last;
        logic               bad_request;
    } t_rsp;

    typedef enum logic [1:0] {
        K_VICTIM = 2'd0,
        K_LAST   = 2'd1,
        K_ERROR  = 2'd2
    } t_out_kind;

    typedef struct packed {
        logic      load;
        logic      build_step;
        logic      init;
        logic      div_start;
        logic      div_step;
        logic      hop_adv;
        logic      vic_capture;
        logic      link_write;
        logic      out_load;
        t_out_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic build_done;
        logic div_done;
        logic rem_gt1;
        logic walk_zero;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/jep_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jep_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/jep_dp.sv
// Datapath: request registers, ring table, remainder unit, walk and result register.
module jep_dp
    import jep_pkg::*;
#(
    parameter int MAX_PEOPLE = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_rsp_valid,
    input  logic  i_rsp_ready,
    output t_rsp  o_rsp
);

    localparam int AW = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;

    logic [LABEL_W-1:0] r_n;
    logic [LABEL_W-1:0] r_k;
    logic [STEP_W-1:0]  r_m;
    logic [LABEL_W-1:0] r_idx;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_victim;
    logic [LABEL_W-1:0] r_rem;
    logic [STEP_W-1:0]  r_div;
    logic [LABEL_W-1:0] r_rmd;
    logic [CNT_W-1:0]   r_cnt;
    t_rsp               r_out;
    logic               r_out_valid;

    logic [AW-1:0]      w_rdata;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_wdata;
    logic [AW-1:0]      w_build_next;
    logic [LABEL_W-1:0] w_idx_inc;
    logic [LABEL_W:0]   w_shift;
    logic               w_ge;
    logic [LABEL_W-1:0] n_rmd;
    t_rsp               n_out;

    assign w_idx_inc    = r_idx + LABEL_W'(1);
    assign w_build_next = (w_idx_inc < r_n) ? w_idx_inc[AW-1:0] : '0;

    assign w_raddr = i_cmd.vic_capture ? w_rdata : r_pos;
    assign w_we    = i_cmd.build_step | i_cmd.link_write;
    assign w_waddr = i_cmd.build_step ? r_idx[AW-1:0] : r_pos;
    assign w_wdata = i_cmd.build_step ? w_build_next : w_rdata;

    jep_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_PEOPLE),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_shift = {r_rmd, r_div[STEP_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_rem};
    assign n_rmd   = w_ge ? LABEL_W'(w_shift - {1'b0, r_rem}) : w_shift[LABEL_W-1:0];

    always_comb begin
        n_out = '0;
        case (i_cmd.out_kind)
            K_VICTIM: begin
                n_out.removed_label = LABEL_W'(r_victim) + LABEL_W'(1);
            end
            K_LAST: begin
                n_out.removed_label = LABEL_W'(r_pos) + LABEL_W'(1);
                n_out.is_last       = 1'b1;
            end
            K_ERROR: begin
                n_out.is_last     = 1'b1;
                n_out.bad_request = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_req.person_count;
            r_k   <= i_req.start_label;
            r_m   <= i_req.step_count;
            r_idx <= '0;
        end
        if (i_cmd.build_step) begin
            r_idx <= w_idx_inc;
        end
        if (i_cmd.init) begin
            r_pos <= (r_k >= LABEL_W'(2)) ? AW'(r_k - LABEL_W'(2)) : AW'(r_n - LABEL_W'(1));
            r_rem <= r_n;
        end
        if (i_cmd.div_start) begin
            r_div <= r_m - STEP_W'(1);
            r_rmd <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div <= {r_div[STEP_W-2:0], 1'b0};
            r_rmd <= n_rmd;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.hop_adv) begin
            r_pos <= w_rdata;
            r_rmd <= r_rmd - LABEL_W'(1);
        end
        if (i_cmd.vic_capture) begin
            r_victim <= w_rdata;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
            if (i_cmd.out_kind == K_VICTIM) begin
                r_rem <= r_rem - LABEL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.bad = (r_n == '0) || (r_n > LABEL_W'(MAX_PEOPLE)) || (r_k == '0) ||
                        (r_k > r_n) || (r_m == '0);
    assign o_stat.build_done = r_idx == (r_n - LABEL_W'(1));
    assign o_stat.div_done   = r_cnt == CNT_W'(STEP_W - 1);
    assign o_stat.rem_gt1    = r_rem > LABEL_W'(1);
    assign o_stat.walk_zero  = r_rmd == '0;
    assign o_stat.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

>>> rtl/jep_ctrl.sv
// Controller state machine sequencing build, remainder, walk and removal.
module jep_ctrl
    import jep_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHECK = 13'b0000000000010,
        S_BUILD = 13'b0000000000100,
        S_INIT  = 13'b0000000001000,
        S_TEST  = 13'b0000000010000,
        S_DIV   = 13'b0000000100000,
        S_HOP   = 13'b0000001000000,
        S_HOPW  = 13'b0000010000000,
        S_VIC   = 13'b0000100000000,
        S_LINK  = 13'b0001000000000,
        S_EMIT  = 13'b0010000000000,
        S_LAST  = 13'b0100000000000,
        S_ERR   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.bad ? S_ERR : S_BUILD;
            end
            S_BUILD: begin
                o_cmd.build_step = 1'b1;
                if (i_stat.build_done) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_TEST;
            end
            S_TEST: begin
                if (i_stat.rem_gt1) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_HOP;
                end
            end
            S_HOP: begin
                n_state = i_stat.walk_zero ? S_VIC : S_HOPW;
            end
            S_HOPW: begin
                o_cmd.hop_adv = 1'b1;
                n_state       = S_HOP;
            end
            S_VIC: begin
                o_cmd.vic_capture = 1'b1;
                n_state           = S_LINK;
            end
            S_LINK: begin
                o_cmd.link_write = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.out_kind = K_VICTIM;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_TEST;
                end
            end
            S_LAST: begin
                o_cmd.out_kind = K_LAST;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ERR: begin
                o_cmd.out_kind = K_ERROR;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/josephus_elimination_order.sv
// Top level of the Josephus elimination order block.
// One request (n, k, m) gives n results in removal order, the survivor last with is_last
// set, or one result with bad_request set when n, k or m is out of range. The ring of
// successors is rebuilt in a RAM for each request, then every removal takes a bit-serial
// remainder of (m-1) mod r with r people left, a registered RAM read per ring link walked,
// and the unlink. Results wait in an output register while the next removal is worked out.
module josephus_elimination_order
    import jep_pkg::*;
#(
    parameter int MAX_PEOPLE = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;

    jep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    jep_dp #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result register overwritten before transfer");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !w_cmd.out_load && !w_cmd.link_write && !w_cmd.build_step)
        else $error("datapath active while idle");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.bad_request) |-> (o_rsp.is_last && o_rsp.removed_label == '0))
        else $error("malformed error result");

    a_label_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.bad_request) |->
            (o_rsp.removed_label != '0 && o_rsp.removed_label <= LABEL_W'(MAX_PEOPLE)))
        else $error("removed label out of range");

endmodule

>>> verif/tb_josephus_elimination_order.sv
// Self-checking testbench for josephus_elimination_order: directed table plus random requests.
module tb_josephus_elimination_order
    import jep_pkg::*;
();

    localparam int RING_MAX   = 64;
    localparam int HOLD_LEN   = 600;
    localparam int RANDOM_REQ = 100;

    typedef struct packed {
        logic [LABEL_W-1:0] n;
        logic [LABEL_W-1:0] k;
        logic [STEP_W-1:0]  m;
        logic               typed;
        t_rsp               want;
    } t_dir_row;

    localparam t_rsp REJECT  = '{7'd0, 1'b1, 1'b1};
    localparam t_rsp ALONE   = '{7'd1, 1'b1, 1'b0};
    localparam t_rsp NO_WANT = '{7'd0, 1'b0, 1'b0};

    localparam t_dir_row DIRECTED [18] = '{
        '{7'd0,   7'd0,   16'd0,     1'b1, REJECT},
        '{7'd0,   7'd1,   16'd1,     1'b1, REJECT},
        '{7'd5,   7'd0,   16'd2,     1'b1, REJECT},
        '{7'd5,   7'd6,   16'd2,     1'b1, REJECT},
        '{7'd5,   7'd1,   16'd0,     1'b1, REJECT},
        '{7'd65,  7'd1,   16'd1,     1'b1, REJECT},
        '{7'd127, 7'd127, 16'd65535, 1'b1, REJECT},
        '{7'd1,   7'd1,   16'd1,     1'b1, ALONE},
        '{7'd1,   7'd1,   16'd65535, 1'b1, ALONE},
        '{7'd7,   7'd1,   16'd3,     1'b0, NO_WANT},
        '{7'd10,  7'd1,   16'd1,     1'b0, NO_WANT},
        '{7'd2,   7'd2,   16'd2,     1'b0, NO_WANT},
        '{7'd41,  7'd1,   16'd3,     1'b0, NO_WANT},
        '{7'd13,  7'd13,  16'd65535, 1'b0, NO_WANT},
        '{7'd3,   7'd2,   16'd65534, 1'b0, NO_WANT},
        '{7'd64,  7'd1,   16'd1,     1'b0, NO_WANT},
        '{7'd64,  7'd32,  16'd2,     1'b0, NO_WANT},
        '{7'd64,  7'd64,  16'd65535, 1'b0, NO_WANT}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp_data;

    t_rsp expected_order [$];
    logic [5:0] ring_next [RING_MAX];
    int   ring_pos;
    int   ring_left;

    bit   no_idle = 1'b0;
    bit   hold_rsp_pending = 1'b0;
    int   label_mismatches = 0;
    int   requests_sent = 0;
    int   requests_rejected = 0;
    int   labels_checked = 0;
    int   widest_ring = 0;

    always #5 clk = ~clk;

    josephus_elimination_order dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_data),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_data)
    );

    function automatic t_rsp make_rsp(input int label, input bit last, input bit bad);
        t_rsp r;
        r.removed_label = LABEL_W'(label);
        r.is_last       = last;
        r.bad_request   = bad;
        return r;
    endfunction

    function automatic void predict_elimination(input t_req req);
        int n;
        int k;
        int m;
        int walk;
        int victim;
        n = req.person_count;
        k = req.start_label;
        m = req.step_count;
        if (n < 1 || n > RING_MAX || k < 1 || k > n || m < 1) begin
            requests_rejected++;
            expected_order.push_back(make_rsp(0, 1'b1, 1'b1));
            return;
        end
        if (n > widest_ring) widest_ring = n;
        for (int i = 0; i < n; i++) ring_next[i] = 6'((i + 1 < n) ? i + 1 : 0);
        ring_pos  = (k >= 2) ? k - 2 : n - 1;
        ring_left = n;
        while (ring_left > 1) begin
            walk = (m - 1) % ring_left;
            repeat (walk) ring_pos = ring_next[ring_pos];
            victim = ring_next[ring_pos];
            expected_order.push_back(make_rsp(victim + 1, 1'b0, 1'b0));
            ring_next[ring_pos] = ring_next[victim];
            ring_left--;
        end
        expected_order.push_back(make_rsp(ring_pos + 1, 1'b1, 1'b0));
    endfunction

    function automatic t_req random_request();
        t_req r;
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        r.step_count = STEP_W'($urandom());
        if (sel < 14) begin
            case ($urandom_range(0, 4))
                0: begin
                    r.person_count = '0;
                    r.start_label  = LABEL_W'($urandom_range(0, 127));
                end
                1: begin
                    r.person_count = LABEL_W'($urandom_range(RING_MAX + 1, 127));
                    r.start_label  = LABEL_W'($urandom_range(0, 127));
                end
                2: begin
                    r.person_count = LABEL_W'($urandom_range(1, RING_MAX));
                    r.start_label  = '0;
                end
                3: begin
                    n = $urandom_range(1, RING_MAX);
                    r.person_count = LABEL_W'(n);
                    r.start_label  = LABEL_W'($urandom_range(n + 1, 127));
                end
                default: begin
                    n = $urandom_range(1, RING_MAX);
                    r.person_count = LABEL_W'(n);
                    r.start_label  = LABEL_W'($urandom_range(1, n));
                    r.step_count   = '0;
                end
            endcase
        end else begin
            n = (sel < 22) ? $urandom_range(33, RING_MAX) : $urandom_range(1, 16);
            r.person_count = LABEL_W'(n);
            r.start_label  = LABEL_W'($urandom_range(1, n));
            if (sel >= 22 && $urandom_range(0, 3) != 0) begin
                r.step_count = STEP_W'($urandom_range(1, 12));
            end else if (r.step_count == '0) begin
                r.step_count = STEP_W'($urandom_range(1, 65535));
            end
        end
        return r;
    endfunction

    task automatic offer_request(input t_req req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        requests_sent++;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (expected_order.size() != 0);
    endtask

    function automatic void note_mismatch(input string what, input t_rsp want, input t_rsp got);
        label_mismatches++;
        if (label_mismatches <= 10) begin
            $display("%s: expected label %0d last %0b bad %0b, got label %0d last %0b bad %0b",
                     what, want.removed_label, want.is_last, want.bad_request,
                     got.removed_label, got.is_last, got.bad_request);
        end
    endfunction

    initial begin
        t_req req;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED[i]) begin
            req.person_count = DIRECTED[i].n;
            req.start_label  = DIRECTED[i].k;
            req.step_count   = DIRECTED[i].m;
            offer_request(req);
            if (DIRECTED[i].typed) begin
                if (DIRECTED[i].want.bad_request) requests_rejected++;
                expected_order.push_back(DIRECTED[i].want);
            end else begin
                predict_elimination(req);
            end
        end
        drain_results();
        for (int i = 0; i < RANDOM_REQ; i++) begin
            if (i == 20) hold_rsp_pending = 1'b1;
            no_idle = (i >= 40 && i < 60);
            if (i == 70) drain_results();
            req = random_request();
            offer_request(req);
            predict_elimination(req);
        end
        drain_results();
        repeat (200) @(posedge clk);
        $display("Covered %0d requests, %0d rejected, %0d results checked, rings up to %0d.",
                 requests_sent, requests_rejected, labels_checked, widest_ring);
        if (label_mismatches == 0) begin
            $display("tb_josephus_elimination_order passed");
        end else begin
            $display("%0d mismatches", label_mismatches);
            $display("tb_josephus_elimination_order failed");
        end
        $finish;
    end

    initial begin
        int gap;
        t_rsp want;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_rsp_pending) begin
                gap = HOLD_LEN;
                hold_rsp_pending = 1'b0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            labels_checked++;
            if (expected_order.size() == 0) begin
                note_mismatch("unexpected result", NO_WANT, rsp_data);
            end else begin
                want = expected_order.pop_front();
                if (rsp_data.removed_label !== want.removed_label ||
                    rsp_data.is_last !== want.is_last ||
                    rsp_data.bad_request !== want.bad_request) begin
                    note_mismatch("result mismatch", want, rsp_data);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d results outstanding", expected_order.size());
        $display("tb_josephus_elimination_order failed");
        $finish;
    end

endmodule
